[sv/smp_pkg.sv]
`timescale 1ns / 1ps

package smp_pkg;

  localparam int WIN_DEPTH   = 16;
  localparam int PAT_BITS    = 128;
  localparam int LEN_W       = 5;
  localparam int COUNT_W     = 9;
  localparam int START_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_W    = 2;
  localparam int OQ_CNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

  localparam logic [START_W-1:0] START_SAT = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 9'h1FF;

  typedef struct packed {
    logic       shift;
    logic [7:0] pat;
  } cell_ctl_t;

  typedef struct packed {
    logic [START_W-1:0] match_start;
    logic               is_match;
    logic [COUNT_W-1:0] match_total;
    logic               text_overflow;
    logic               end_of_text;
  } oq_item_t;

  function automatic logic [7:0] pat_byte(input logic [PAT_BITS-1:0] pat,
                                          input logic [3:0] idx);
    return pat[{idx, 3'b000} +: 8];
  endfunction

endpackage

[sv/smp_cell.sv]
`timescale 1ns / 1ps

module smp_cell
  import smp_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [7:0] din,
  output logic [7:0] dout,
  output logic       eq
);

  logic [7:0] byte_r;

  assign eq   = (din == ctl.pat);
  assign dout = byte_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= din;
    end
  end

endmodule

[sv/smp_outq.sv]
`timescale 1ns / 1ps

module smp_outq
  import smp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic [1:0] push_n,
  input  oq_item_t first,
  input  oq_item_t second,
  input  logic     pop,
  output oq_item_t head,
  output logic     not_empty,
  output logic     room
);

  oq_item_t              mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wp_r, wp_nxt;
  logic [OQ_PTR_W-1:0]   rp_r, rp_nxt;
  logic [OQ_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign head      = mem[rp_r];
  assign not_empty = (cnt_r != '0);
  assign room      = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + OQ_PTR_W'(push_n);
    rp_nxt  = rp_r + OQ_PTR_W'(pop);
    cnt_nxt = cnt_r + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp_r] <= first;
    end
    if (push_n == 2'd2) begin
      mem[wp_r + OQ_PTR_W'(1)] <= second;
    end
  end

endmodule

[sv/substring_match_positions_unit.sv]
`timescale 1ns / 1ps
// Streaming search for every occurrence of a configured pattern of 1 to 16 bytes.
// Input beats carry one text byte each, with in_text_last marking the final byte.
// Each accepted byte shifts into a row of window cells; every cell compares the
// byte it takes in with its pattern byte, and a full match yields one output beat
// with the start offset and the running match count. The final byte of a text also
// yields a closing beat with the total and the overflow flag, then the per-text
// counters clear for the next text.
// Throughput is one text byte per cycle while the queue has room; the window row
// shifts and compares each accepted byte. Results are registered in a four-entry
// output queue before they reach the output. A byte that yields both a match beat
// and a closing beat pushes both beats into the queue. The input is stalled while
// the queue lacks room for two beats, so during an output stall bytes keep being
// taken until the queue holds three or four beats. Reset empties the queue,
// clears the counters and sets the pattern length to one with an all-zero
// pattern. Configuration must be written only while idle; unchecked by the block.
module substring_match_positions_unit
  import smp_pkg::*;
#(
  parameter int PATTERN_MAX = 16,
  parameter int TEXT_MAX    = 256
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_text_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [START_W-1:0]    out_match_start,
  output logic                  out_is_match,
  output logic [COUNT_W-1:0]    out_match_total,
  output logic                  out_text_overflow,
  output logic                  out_end_of_text
);

  localparam int CELLS  = (PATTERN_MAX < WIN_DEPTH) ? PATTERN_MAX : WIN_DEPTH;
  localparam int SEEN_W = $clog2(TEXT_MAX + 1);

  logic [CFG_DATA_W-1:0] pat_lo_r, pat_hi_r;
  logic [LEN_W-1:0]      pat_len_r;
  logic [SEEN_W-1:0]     seen_r, seen_nxt;
  logic [COUNT_W-1:0]    found_r, found_nxt;
  logic                  ovf_r, ovf_nxt;

  logic                  in_acc;
  logic [LEN_W-1:0]      eff_len;
  logic [7:0]            chain [CELLS+1];
  logic [CELLS-1:0]      eq_v, act_v;
  logic                  hit;
  logic [SEEN_W:0]       pos_inc;
  logic [SEEN_W:0]       start_full;
  logic [START_W-1:0]    start;
  logic [1:0]            push_n;
  oq_item_t              first, second, head;
  logic                  q_room, q_pop;

  assign in_acc  = in_valid & ~in_stall;
  assign in_stall = ~q_room;
  assign eff_len = (pat_len_r > LEN_W'(CELLS)) ? LEN_W'(CELLS) : pat_len_r;

  assign chain[0] = in_text_byte;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    cell_ctl_t        ctl;
    logic [3:0]       idx;

    assign idx     = 4'(eff_len - LEN_W'(1) - LEN_W'(k));
    assign ctl.shift = in_acc;
    assign ctl.pat   = pat_byte({pat_hi_r, pat_lo_r}, idx);
    assign act_v[k]  = (LEN_W'(k) < eff_len);

    smp_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .din  (chain[k]),
      .dout (chain[k+1]),
      .eq   (eq_v[k])
    );
  end

  always_comb begin
    pos_inc = {1'b0, seen_r} + (SEEN_W+1)'(1);
    ovf_nxt = ovf_r | (seen_r >= SEEN_W'(TEXT_MAX));
    seen_nxt = (seen_r >= SEEN_W'(TEXT_MAX)) ? seen_r : seen_r + SEEN_W'(1);
    hit = (eff_len != '0) && (pos_inc >= (SEEN_W+1)'(eff_len)) && (&(eq_v | ~act_v));
    start_full = pos_inc - (SEEN_W+1)'(eff_len);
    if (ovf_nxt || (start_full > (SEEN_W+1)'(START_SAT))) begin
      start = START_SAT;
    end else begin
      start = start_full[START_W-1:0];
    end
    found_nxt = (hit && (found_r != COUNT_SAT)) ? found_r + COUNT_W'(1) : found_r;

    first.match_start   = hit ? start : '0;
    first.is_match      = hit;
    first.match_total   = found_nxt;
    first.text_overflow = ovf_nxt;
    first.end_of_text   = ~hit;

    second.match_start   = '0;
    second.is_match      = 1'b0;
    second.match_total   = found_nxt;
    second.text_overflow = ovf_nxt;
    second.end_of_text   = 1'b1;

    push_n = in_acc ? (2'(hit) + 2'(in_text_last)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_LO:  pat_lo_r  <= cfg_wdata;
        REG_PAT_HI:  pat_hi_r  <= cfg_wdata;
        REG_PAT_LEN: pat_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      found_r <= '0;
      ovf_r   <= 1'b0;
    end else if (in_acc) begin
      if (in_text_last) begin
        seen_r  <= '0;
        found_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        seen_r  <= seen_nxt;
        found_r <= found_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  assign q_pop = out_valid & ~out_stall;

  smp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .first     (first),
    .second    (second),
    .pop       (q_pop),
    .head      (head),
    .not_empty (out_valid),
    .room      (q_room)
  );

  assign out_match_start   = head.match_start;
  assign out_is_match      = head.is_match;
  assign out_match_total   = head.match_total;
  assign out_text_overflow = head.text_overflow;
  assign out_end_of_text   = head.end_of_text;

endmodule

[sv/smp_checker.sv]
`timescale 1ns / 1ps

module smp_checker
  import smp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [START_W-1:0] out_match_start,
  input logic               out_is_match,
  input logic [COUNT_W-1:0] out_match_total,
  input logic               out_text_overflow,
  input logic               out_end_of_text
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_start) &&
    $stable(out_match_total) && $stable(out_end_of_text))
    else $error("stalled result beat changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> !out_is_match && out_match_start == '0)
    else $error("closing beat carries a match");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_match |-> out_match_total != '0 && !out_end_of_text)
    else $error("match beat with zero total");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_match && out_text_overflow |-> out_match_start == START_SAT)
    else $error("offset not saturated after overflow");

endmodule

bind substring_match_positions_unit smp_checker u_smp_checker (.*);

[test/substring_match_positions_unit_tb.sv]
`timescale 1ns / 1ps

module substring_match_positions_unit_tb;
  import smp_pkg::*;

  localparam int PATTERN_CAP = 16;
  localparam int TEXT_LIMIT = 256;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 150;
  localparam int OVERFLOW_BYTES = 280;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [7:0] FILL_BYTE = 8'h5A;
  localparam oq_item_t NO_BEAT = '0;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [7:0] text_byte;
    logic text_last;
    int reps;
    int typed_n;
    oq_item_t typed_a;
    oq_item_t typed_b;
  } directed_step_t;

  localparam int N_STEPS = 22;

  // A typed_n of -1 leaves the expected beats to the search model.
  directed_step_t directed_steps [N_STEPS] = '{
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'h00, 1'b0, 1, 1, '{8'd0, 1'b1, 9'd1, 1'b0, 1'b0}, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'hFF, 1'b1, 1, 1, '{8'd0, 1'b0, 9'd1, 1'b0, 1'b1}, NO_BEAT},
    '{ROW_CFG, REG_UNUSED, '1, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'h00, 1'b1, 1, 2, '{8'd0, 1'b1, 9'd1, 1'b0, 1'b0},
      '{8'd0, 1'b0, 9'd1, 1'b0, 1'b1}},
    '{ROW_CFG, REG_PAT_LO, 64'd0, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_CFG, REG_PAT_HI, 64'd0, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_CFG, REG_PAT_LEN, 64'd2, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'h00, 1'b1, 1, 1, '{8'd0, 1'b0, 9'd0, 1'b0, 1'b1}, NO_BEAT},
    '{ROW_CFG, REG_PAT_LEN, 64'd0, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'h00, 1'b1, 1, 1, '{8'd0, 1'b0, 9'd0, 1'b0, 1'b1}, NO_BEAT},
    '{ROW_CFG, REG_PAT_LO, 64'h616261, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_CFG, REG_PAT_LEN, 64'd3, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'h61, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'h62, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'h61, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'h62, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'h61, 1'b1, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_CFG, REG_PAT_LO, '1, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_CFG, REG_PAT_HI, '1, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_CFG, REG_PAT_LEN, 64'd31, 8'h00, 1'b0, 1, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'hFF, 1'b0, 15, -1, NO_BEAT, NO_BEAT},
    '{ROW_BYTE, REG_PAT_LO, 64'd0, 8'hFF, 1'b1, 1, 2, '{8'd0, 1'b1, 9'd1, 1'b0, 1'b0},
      '{8'd0, 1'b0, 9'd1, 1'b0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PAT_LO;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic in_text_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [START_W-1:0] out_match_start;
  logic out_is_match;
  logic [COUNT_W-1:0] out_match_total;
  logic out_text_overflow;
  logic out_end_of_text;

  substring_match_positions_unit #(
    .PATTERN_MAX(PATTERN_CAP),
    .TEXT_MAX(TEXT_LIMIT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_text_byte(in_text_byte),
    .in_text_last(in_text_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_match_start(out_match_start),
    .out_is_match(out_is_match),
    .out_match_total(out_match_total),
    .out_text_overflow(out_text_overflow),
    .out_end_of_text(out_end_of_text)
  );

  // Search model state, mirrored from the block.
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [4:0] pat_len = 5'd1;
  logic [7:0] window [WIN_DEPTH];
  int unsigned text_seen = 0;
  int unsigned found_total = 0;
  logic text_ovf = 1'b0;

  oq_item_t expected_beats [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  longint cycles = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int settings_used = 0;
  int beats_checked = 0;
  int overflow_closes = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding.", cycles,
               expected_beats.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    oq_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (out_end_of_text && out_text_overflow) overflow_closes++;
      if (expected_beats.size() == 0) begin
        $error("Unexpected output beat: match_start %0d, total %0d, end_of_text %0b",
               out_match_start, out_match_total, out_end_of_text);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_match_start !== want.match_start) begin
          $error("match_start: expected %0d, got %0d", want.match_start, out_match_start);
          error_count++;
        end
        if (out_is_match !== want.is_match) begin
          $error("is_match: expected %0d, got %0d", want.is_match, out_is_match);
          error_count++;
        end
        if (out_match_total !== want.match_total) begin
          $error("match_total: expected %0d, got %0d", want.match_total, out_match_total);
          error_count++;
        end
        if (out_text_overflow !== want.text_overflow) begin
          $error("text_overflow: expected %0d, got %0d", want.text_overflow,
                 out_text_overflow);
          error_count++;
        end
        if (out_end_of_text !== want.end_of_text) begin
          $error("end_of_text: expected %0d, got %0d", want.end_of_text, out_end_of_text);
          error_count++;
        end
      end
    end
  end

  function automatic logic [7:0] pattern_at(int idx);
    if (idx < 8) return pat_lo[8*idx +: 8];
    return pat_hi[8*(idx-8) +: 8];
  endfunction

  function automatic int effective_length();
    return (pat_len > PATTERN_CAP) ? PATTERN_CAP : int'(pat_len);
  endfunction

  task automatic clear_text();
    int k;
    for (k = 0; k < WIN_DEPTH; k++) window[k] = 8'h00;
    text_seen = 0;
    found_total = 0;
    text_ovf = 1'b0;
  endtask

  // Shifts one text byte into the window and queues the beats it causes.
  task automatic search_step(input logic [7:0] b, input logic last, input bit record);
    int eff;
    int unsigned pos;
    int k;
    bit hit;
    oq_item_t beat;
    eff = effective_length();
    pos = text_seen;
    for (k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (text_seen >= TEXT_LIMIT) text_ovf = 1'b1;
    else text_seen++;
    hit = (eff > 0) && (pos + 1 >= eff);
    for (k = 0; k < eff; k++) begin
      if (window[k] != pattern_at(eff - 1 - k)) hit = 1'b0;
    end
    if (hit) begin
      if (found_total < COUNT_SAT) found_total++;
      beat.match_start = (text_ovf || pos + 1 - eff > START_SAT) ? START_SAT :
                         START_W'(pos + 1 - eff);
      beat.is_match = 1'b1;
      beat.match_total = COUNT_W'(found_total);
      beat.text_overflow = text_ovf;
      beat.end_of_text = 1'b0;
      if (record) expected_beats.push_back(beat);
    end
    if (last) begin
      beat.match_start = '0;
      beat.is_match = 1'b0;
      beat.match_total = COUNT_W'(found_total);
      beat.text_overflow = text_ovf;
      beat.end_of_text = 1'b1;
      if (record) expected_beats.push_back(beat);
      clear_text();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit record);
    while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_text_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    search_step(b, last, record);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_PAT_LO: pat_lo = val;
      REG_PAT_HI: pat_hi = val;
      REG_PAT_LEN: pat_len = val[LEN_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode % 4)
      0: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct = 69;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 69;
      end
      default: begin
        idle_pct = 19;
        stall_pct = 19;
      end
    endcase
  endtask

  // Most of a text is copies of the pattern and bytes drawn from it, with
  // truncated copies and arbitrary bytes mixed in.
  task automatic send_random_text(input int n_bytes);
    logic [7:0] text_q [$];
    int eff;
    int r;
    int cut;
    int k;
    eff = effective_length();
    while (text_q.size() < n_bytes) begin
      r = $urandom_range(99);
      if (r < 45 && eff > 0) begin
        cut = (r < 8) ? $urandom_range(eff) : eff;
        for (k = 0; k < cut; k++) text_q.push_back(pattern_at(k));
      end else if (r < 75) begin
        text_q.push_back(pattern_at($urandom_range(15)));
      end else begin
        text_q.push_back(8'($urandom_range(255)));
      end
    end
    for (k = 0; k < n_bytes; k++) send_byte(text_q[k], k == n_bytes - 1, 1'b1);
  endtask

  task automatic random_pattern();
    logic [7:0] bytes [PATTERN_CAP];
    logic [7:0] alpha_a;
    logic [7:0] alpha_b;
    bit narrow;
    int k;
    int pick;
    logic [4:0] len;
    alpha_a = 8'($urandom_range(255));
    alpha_b = 8'($urandom_range(255));
    narrow = ($urandom_range(1) == 1);
    for (k = 0; k < PATTERN_CAP; k++) begin
      if (narrow) bytes[k] = $urandom_range(1) ? alpha_a : alpha_b;
      else bytes[k] = 8'($urandom_range(255));
    end
    pick = $urandom_range(9);
    if (pick < 6) len = 5'($urandom_range(1, 4));
    else if (pick < 8) len = 5'($urandom_range(5, 16));
    else if (pick == 8) len = $urandom_range(1) ? 5'd16 : 5'd31;
    else len = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
    write_reg(REG_PAT_LO, {bytes[7], bytes[6], bytes[5], bytes[4],
                           bytes[3], bytes[2], bytes[1], bytes[0]});
    write_reg(REG_PAT_HI, {bytes[15], bytes[14], bytes[13], bytes[12],
                           bytes[11], bytes[10], bytes[9], bytes[8]});
    write_reg(REG_PAT_LEN, CFG_DATA_W'(len));
    settings_used++;
  endtask

  initial begin
    int i;
    int k;
    int phase;
    int n_texts;
    int start_bytes;
    clear_text();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_STEPS; i++) begin
      if (directed_steps[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
        settings_used++;
      end else begin
        for (k = 0; k < directed_steps[i].reps; k++) begin
          send_byte(directed_steps[i].text_byte, directed_steps[i].text_last,
                    directed_steps[i].typed_n < 0);
        end
        if (directed_steps[i].typed_n > 0) expected_beats.push_back(directed_steps[i].typed_a);
        if (directed_steps[i].typed_n > 1) expected_beats.push_back(directed_steps[i].typed_b);
      end
    end

    // One long text of single-byte matches runs past the text limit, with
    // both sides pausing now and then.
    wait_drained();
    write_reg(REG_PAT_LO, CFG_DATA_W'(FILL_BYTE));
    write_reg(REG_PAT_LEN, 64'd1);
    settings_used++;
    set_idle_mode(3);
    for (k = 0; k < OVERFLOW_BYTES; k++) begin
      send_byte((k % 64 == 63) ? 8'($urandom_range(255)) : FILL_BYTE,
                k == OVERFLOW_BYTES - 1, 1'b1);
    end

    start_bytes = bytes_sent;
    phase = 0;
    while ((phase < 4) || (bytes_sent - start_bytes < RANDOM_ITEMS)) begin
      wait_drained();
      random_pattern();
      set_idle_mode(phase);
      n_texts = $urandom_range(2, 4);
      for (k = 0; k < n_texts; k++) begin
        send_random_text($urandom_range(1, 32));
      end
      phase++;
    end

    wait_drained();
    $display("Sent %0d text bytes in %0d texts under %0d pattern settings; %0d beats checked.",
             bytes_sent, texts_sent, settings_used, beats_checked);
    $display("Texts closed with overflow: %0d.", overflow_closes);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
sv/smp_pkg.sv
sv/smp_cell.sv
sv/smp_outq.sv
sv/substring_match_positions_unit.sv
sv/smp_checker.sv
test/substring_match_positions_unit_tb.sv
